// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL files of the address text checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge while reset is released.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition never holds while reset is released.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: rtl/core/ipv6tv_pkg.sv
// ----------------------------------------------------------------------------
// ipv6tv_pkg
// Types and constants shared by the IPv6 address text checker.
// ----------------------------------------------------------------------------
package ipv6tv_pkg;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned COUNT_W = 6;
    localparam int unsigned DIGIT_W = 3;

    localparam logic [CHAR_W-1:0]  COLON_CODE       = 8'h3A;
    localparam logic [COUNT_W-1:0] COUNT_CAP        = 6'd63;
    localparam logic [COUNT_W-1:0] MIN_TEXT_LEN     = 6'd2;
    localparam logic [DIGIT_W-1:0] DIGIT_CAP        = 3'd7;
    localparam logic [DIGIT_W-1:0] GROUP_MAX_DIGITS = 3'd4;

    // Classification of one character of the text.
    typedef struct packed {
        logic is_colon;
        logic is_hex;
    } t_char_class;

endpackage

// File: rtl/core/ipv6_text_validator_unit.sv
// A final character is reported through the input register and then the result register.
// Throughput: one character per cycle; only a final character waits, when the output is stalled.
// The per-character state update is one short pass of compare and increment logic.
// Reset (i_rst_n low, synchronous) empties both registers and clears the text state.
// ----------------------------------------------------------------------------
// ipv6_text_validator_unit
// Checks an IPv6 address text, one character per transaction, and gives one
// verdict per text on its final character.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ipv6_text_validator_unit #(
    parameter int unsigned MAX_TEXT_LEN = 46
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_char_code,
    input  logic       i_last_char,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_is_valid
);
    import ipv6tv_pkg::*;

    logic [CHAR_W-1:0] r_in_char;
    logic              r_in_last;
    logic              r_in_valid;
    logic              r_out_valid;
    logic              r_out_is_valid;
    logic              w_out_free;
    logic              w_consume;
    logic              w_is_valid;
    t_char_class       w_class;

    assign w_out_free = !r_out_valid || !i_stall;
    // Only a final character needs room in the result register.
    assign w_consume  = r_in_valid && (!r_in_last || w_out_free);
    assign o_stall    = r_in_valid && !w_consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_char <= i_char_code;
            r_in_last <= i_last_char;
        end
    end

    ipv6tv_classify u_classify (
        .i_char_code (r_in_char),
        .o_class     (w_class)
    );

    ipv6tv_state #(
        .MAX_TEXT_LEN (MAX_TEXT_LEN)
    ) u_state (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (w_consume),
        .i_last     (r_in_last),
        .i_class    (w_class),
        .o_is_valid (w_is_valid)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_consume && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_consume && r_in_last) begin
            r_out_is_valid <= w_is_valid;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_is_valid = r_out_is_valid;

    `ASSERT_CLK(a_result_from_last, i_clk, i_rst_n, $rose(o_valid) |-> $past(w_consume && r_in_last), "result without a final character")
    `ASSERT_CLK(a_last_gives_result, i_clk, i_rst_n, (w_consume && r_in_last) |=> o_valid, "final character produced no result")
    `ASSERT_NEVER(a_stall_needs_item, i_clk, i_rst_n, o_stall && !r_in_valid, "input stalled with an empty input register")

endmodule

// File: rtl/core/ipv6tv_classify.sv
// ----------------------------------------------------------------------------
// ipv6tv_classify
// Decodes one ASCII character into colon and hexadecimal digit flags.
// ----------------------------------------------------------------------------
module ipv6tv_classify (
    input  logic [7:0]               i_char_code,
    output ipv6tv_pkg::t_char_class  o_class
);
    import ipv6tv_pkg::*;

    always_comb begin
        o_class.is_colon = (i_char_code == COLON_CODE);
        o_class.is_hex   = ((i_char_code >= 8'h30) && (i_char_code <= 8'h39)) ||
                           ((i_char_code >= 8'h41) && (i_char_code <= 8'h46)) ||
                           ((i_char_code >= 8'h61) && (i_char_code <= 8'h66));
    end

endmodule

// File: rtl/core/ipv6tv_state.sv
// ----------------------------------------------------------------------------
// ipv6tv_state
// Per-text parsing state: character count, colon pairing, group digit count
// and the sticky error flag. Gives the verdict for the final character.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ipv6tv_state #(
    parameter int unsigned MAX_TEXT_LEN = 46
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_take,
    input  logic                     i_last,
    input  ipv6tv_pkg::t_char_class  i_class,
    output logic                     o_is_valid
);
    import ipv6tv_pkg::*;

    localparam logic [COUNT_W-1:0] LP_MAX_LEN = COUNT_W'(MAX_TEXT_LEN);

    logic [COUNT_W-1:0] r_char_count,        n_char_count;
    logic               r_starts_with_colon, n_starts_with_colon;
    logic               r_prev_was_colon,    n_prev_was_colon;
    logic               r_unpaired_colon,    n_unpaired_colon;
    logic               r_double_colon_seen, n_double_colon_seen;
    logic [DIGIT_W-1:0] r_digits_in_group,   n_digits_in_group;
    logic               r_group_seen,        n_group_seen;
    logic               r_error_flag,        n_error_flag;

    always_comb begin
        n_char_count        = r_char_count;
        n_starts_with_colon = r_starts_with_colon;
        n_unpaired_colon    = r_unpaired_colon;
        n_double_colon_seen = r_double_colon_seen;
        n_digits_in_group   = r_digits_in_group;
        n_group_seen        = r_group_seen;
        n_error_flag        = r_error_flag;
        n_prev_was_colon    = i_class.is_colon;

        if (r_char_count >= LP_MAX_LEN) begin
            n_error_flag = 1'b1;
        end
        if (r_char_count < COUNT_CAP) begin
            n_char_count = r_char_count + COUNT_W'(1);
        end

        if (r_char_count == '0) begin
            n_starts_with_colon = i_class.is_colon;
        end else if ((r_char_count == COUNT_W'(1)) && r_starts_with_colon
                     && !i_class.is_colon) begin
            n_error_flag = 1'b1;
        end

        if (i_class.is_colon) begin
            // A waiting colon pairs with this one to form a double colon.
            if (r_unpaired_colon) begin
                if (r_double_colon_seen) begin
                    n_error_flag = 1'b1;
                end
                n_double_colon_seen = 1'b1;
                n_unpaired_colon    = 1'b0;
            end else begin
                n_unpaired_colon = 1'b1;
            end
            n_digits_in_group = '0;
        end else begin
            n_unpaired_colon = 1'b0;
            if (!i_class.is_hex) begin
                n_error_flag = 1'b1;
            end
            if (r_digits_in_group < DIGIT_CAP) begin
                n_digits_in_group = r_digits_in_group + DIGIT_W'(1);
            end
            if (n_digits_in_group > GROUP_MAX_DIGITS) begin
                n_error_flag = 1'b1;
            end
            n_group_seen = 1'b1;
        end

        if (i_last && i_class.is_colon && !r_prev_was_colon) begin
            n_error_flag = 1'b1;
        end
    end

    assign o_is_valid = !n_error_flag && n_group_seen && (n_char_count >= MIN_TEXT_LEN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_last)) begin
            r_char_count        <= '0;
            r_starts_with_colon <= 1'b0;
            r_prev_was_colon    <= 1'b0;
            r_unpaired_colon    <= 1'b0;
            r_double_colon_seen <= 1'b0;
            r_digits_in_group   <= '0;
            r_group_seen        <= 1'b0;
            r_error_flag        <= 1'b0;
        end else if (i_take) begin
            r_char_count        <= n_char_count;
            r_starts_with_colon <= n_starts_with_colon;
            r_prev_was_colon    <= n_prev_was_colon;
            r_unpaired_colon    <= n_unpaired_colon;
            r_double_colon_seen <= n_double_colon_seen;
            r_digits_in_group   <= n_digits_in_group;
            r_group_seen        <= n_group_seen;
            r_error_flag        <= n_error_flag;
        end
    end

    `ASSERT_CLK(a_clear_after_last, i_clk, i_rst_n, (i_take && i_last) |=> (r_char_count == '0), "state not cleared after final character")
    `ASSERT_CLK(a_error_sticky, i_clk, i_rst_n, (r_error_flag && !(i_take && i_last)) |=> r_error_flag, "error flag dropped within a text")
    `ASSERT_NEVER(a_empty_text_flags, i_clk, i_rst_n, (r_char_count == '0) && (r_group_seen || r_starts_with_colon), "flags set with no characters counted")

endmodule
